@@ rtl/core/pinned_address_range_set_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the pinned address range set unit
// Concurrent checks that vanish when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PINNED_ADDRESS_RANGE_SET_UNIT_MACROS_SVH
`define PINNED_ADDRESS_RANGE_SET_UNIT_MACROS_SVH
`ifndef SYNTH
`define PARS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PARS_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PARS_ASSERT(lbl, clk, rst, prop, msg)
`define PARS_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

@@ rtl/core/pars_pkg.sv @@
// ----------------------------------------------------------------------------
// Pinned address range set package
// Sizes, operation codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package pars_pkg;

   localparam int CAPACITY    = 16;
   localparam int MAX_RESULTS = 16;
   localparam int ADDR_W      = 48;
   localparam int SIZE_W      = 32;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_MEMBER  = 2'd1,
      OP_OFFSETS = 2'd2,
      OP_CLEAR   = 2'd3
   } pars_op_type;

   typedef struct packed {
      logic             load;      // capture request word, reset sorter
      logic             rd_en;     // read one table entry
      logic [IDX_W-1:0] rd_idx;
      logic             rsp_load;  // fill the response register
      logic             rsp_emit;  // response comes from the sorter head
   } pars_cmd_type;

   typedef struct packed {
      pars_op_type op;
      logic        cnt_zero;
      logic        cnt_one;
   } pars_sts_type;

endpackage

@@ rtl/core/pars_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one operation word.
// ----------------------------------------------------------------------------
interface pars_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  operation;
   logic [pars_pkg::ADDR_W-1:0] address;
   logic [pars_pkg::SIZE_W-1:0] object_size;

   modport source (output valid, operation, address, object_size, input ready);
   modport sink   (input valid, operation, address, object_size, output ready);
endinterface

@@ rtl/core/pars_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface pars_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        found;
   logic [pars_pkg::SIZE_W-1:0] offset;
   logic                        last;
   logic                        status;

   modport source (output valid, found, offset, last, status, input ready);
   modport sink   (input valid, found, offset, last, status, output ready);
endinterface

@@ rtl/core/pars_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pars_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/pars_dp.sv @@
// ----------------------------------------------------------------------------
// Pinned address range set datapath
// Address table, valid bits, range compare, sorted offset buffer and the
// response register.
// ----------------------------------------------------------------------------
`include "pinned_address_range_set_unit_macros.svh"

module pars_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  pars_pkg::pars_cmd_type      cmd,
   output pars_pkg::pars_sts_type      sts,
   input  logic [1:0]                  req_operation,
   input  logic [pars_pkg::ADDR_W-1:0] req_address,
   input  logic [pars_pkg::SIZE_W-1:0] req_object_size,
   output logic                        rsp_found,
   output logic [pars_pkg::SIZE_W-1:0] rsp_offset,
   output logic                        rsp_last,
   output logic                        rsp_status
);

   // request word
   pars_pkg::pars_op_type       op_ff;
   logic [pars_pkg::ADDR_W-1:0] base_ff;
   logic [pars_pkg::SIZE_W-1:0] size_ff;

   // table
   logic [pars_pkg::CAPACITY-1:0] valid_ff;
   logic [pars_pkg::IDX_W-1:0]    free_idx;
   logic                          full;
   logic [pars_pkg::ADDR_W-1:0]   rd_data;
   logic                          do_write;

   // scan pipeline
   logic                        rd_vld_ff;
   logic                        dup_ff;
   logic                        cand_vld_ff;
   logic [pars_pkg::SIZE_W-1:0] cand_off_ff;
   logic [pars_pkg::ADDR_W:0]   diff;
   logic                        in_range;
   logic                        base_zero;

   // sorted offsets
   logic [pars_pkg::SIZE_W-1:0] offs_ff [pars_pkg::MAX_RESULTS];
   logic [pars_pkg::SIZE_W-1:0] offs_in [pars_pkg::MAX_RESULTS];
   logic [pars_pkg::CNT_W-1:0]  cnt_ff;
   logic [pars_pkg::CNT_W-1:0]  cnt_in;
   logic [pars_pkg::MAX_RESULTS-1:0] gt;
   logic                        pop;
   logic                        drop;

   // response word
   logic                        found_ff;
   logic [pars_pkg::SIZE_W-1:0] offset_ff;
   logic                        last_ff;
   logic                        status_ff;

   pars_ram #(
      .WIDTH (pars_pkg::ADDR_W),
      .DEPTH (pars_pkg::CAPACITY)
   ) u_addr_ram (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (free_idx),
      .wr_data (base_ff),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_idx),
      .rd_data (rd_data)
   );

   assign base_zero = (base_ff == '0);
   assign full      = &valid_ff;

   // lowest free slot
   always_comb begin
      free_idx = '0;
      for (int k = pars_pkg::CAPACITY - 1; k >= 0; k--) begin
         if (!valid_ff[k]) begin
            free_idx = pars_pkg::IDX_W'(k);
         end
      end
   end

   // a nonzero insert with no copy is dropped on a full table and written otherwise
   assign drop     = (op_ff == pars_pkg::OP_INSERT) && !base_zero && !dup_ff && full;
   assign do_write = cmd.rsp_load && !cmd.rsp_emit && (op_ff == pars_pkg::OP_INSERT) &&
                     !base_zero && !dup_ff && !full;

   // stored - base is below size exactly when stored lies in [base, base+size)
   assign diff     = {1'b0, rd_data} - {1'b0, base_ff};
   assign in_range = !diff[pars_pkg::ADDR_W] &&
                     (diff[pars_pkg::ADDR_W-1:pars_pkg::SIZE_W] == '0) &&
                     (diff[pars_pkg::SIZE_W-1:0] < size_ff) && !base_zero;

   assign pop = cmd.rsp_load && cmd.rsp_emit;

   always_comb begin
      for (int k = 0; k < pars_pkg::MAX_RESULTS; k++) begin
         gt[k] = (pars_pkg::CNT_W'(k) >= cnt_ff) || (offs_ff[k] > cand_off_ff);
      end
   end

   // sorted insertion: slots above the new offset move up one, the top falls off
   always_comb begin
      offs_in = offs_ff;
      cnt_in  = cnt_ff;
      if (cmd.load) begin
         cnt_in = '0;
      end else if (cand_vld_ff) begin
         if (gt[0]) begin
            offs_in[0] = cand_off_ff;
         end
         for (int k = 1; k < pars_pkg::MAX_RESULTS; k++) begin
            if (gt[k]) begin
               offs_in[k] = gt[k-1] ? offs_ff[k-1] : cand_off_ff;
            end
         end
         if (cnt_ff != pars_pkg::CNT_W'(pars_pkg::MAX_RESULTS)) begin
            cnt_in = pars_pkg::CNT_W'(cnt_ff + 1'b1);
         end
      end else if (pop) begin
         for (int k = 0; k < pars_pkg::MAX_RESULTS - 1; k++) begin
            offs_in[k] = offs_ff[k+1];
         end
         cnt_in = pars_pkg::CNT_W'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_vld_ff   <= 1'b0;
         dup_ff      <= 1'b0;
         cand_vld_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         if (cmd.load && (pars_pkg::pars_op_type'(req_operation) == pars_pkg::OP_CLEAR)) begin
            valid_ff <= '0;
         end else if (do_write) begin
            valid_ff[free_idx] <= 1'b1;
         end
         rd_vld_ff <= cmd.rd_en && valid_ff[cmd.rd_idx];
         if (cmd.load) begin
            dup_ff <= 1'b0;
         end else if (rd_vld_ff && (rd_data == base_ff)) begin
            dup_ff <= 1'b1;
         end
         cand_vld_ff <= rd_vld_ff && in_range;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= pars_pkg::pars_op_type'(req_operation);
         base_ff <= req_address;
         size_ff <= req_object_size;
      end
      cand_off_ff <= diff[pars_pkg::SIZE_W-1:0];
      offs_ff     <= offs_in;
      if (cmd.rsp_load) begin
         if (cmd.rsp_emit) begin
            found_ff  <= 1'b1;
            offset_ff <= offs_ff[0];
            last_ff   <= (cnt_ff == pars_pkg::CNT_W'(1));
            status_ff <= 1'b0;
         end else begin
            found_ff  <= (op_ff == pars_pkg::OP_MEMBER) && (cnt_ff != '0);
            offset_ff <= '0;
            last_ff   <= 1'b1;
            status_ff <= drop;
         end
      end
   end

   assign sts.op       = op_ff;
   assign sts.cnt_zero = (cnt_ff == '0);
   assign sts.cnt_one  = (cnt_ff == pars_pkg::CNT_W'(1));

   assign rsp_found  = found_ff;
   assign rsp_offset = offset_ff;
   assign rsp_last   = last_ff;
   assign rsp_status = status_ff;

   `PARS_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= pars_pkg::CNT_W'(pars_pkg::MAX_RESULTS), "offset count above buffer depth")
   `PARS_ASSERT(a_sorted_head, clock, reset, (cnt_ff >= pars_pkg::CNT_W'(2)) |-> (offs_ff[0] < offs_ff[1]), "offset buffer out of order")
   `PARS_NEVER(a_insert_pop, clock, reset, cand_vld_ff && pop, "offset insert collides with emit")

endmodule

@@ rtl/core/pars_ctrl.sv @@
// ----------------------------------------------------------------------------
// Pinned address range set controller
// Sequences the table scan, pipeline drain and response delivery.
// ----------------------------------------------------------------------------
`include "pinned_address_range_set_unit_macros.svh"

module pars_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_operation,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output pars_pkg::pars_cmd_type cmd,
   input  pars_pkg::pars_sts_type sts
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN_A,
      ST_DRAIN_B,
      ST_FINISH,
      ST_EMIT
   } state_type;

   state_type                  state_ff;
   state_type                  state_in;
   logic [pars_pkg::IDX_W-1:0] idx_ff;
   logic [pars_pkg::IDX_W-1:0] idx_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic                       accept;
   logic                       rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmd          = '0;
      cmd.rd_idx   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               if (pars_pkg::pars_op_type'(req_operation) == pars_pkg::OP_CLEAR) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            idx_in    = pars_pkg::IDX_W'(idx_ff + 1'b1);
            if (idx_ff == pars_pkg::IDX_W'(pars_pkg::CAPACITY - 1)) begin
               state_in = ST_DRAIN_A;
            end
         end
         // let the last read pass compare and sort
         ST_DRAIN_A: state_in = ST_DRAIN_B;
         ST_DRAIN_B: state_in = ST_FINISH;
         ST_FINISH: begin
            if ((sts.op == pars_pkg::OP_OFFSETS) && !sts.cnt_zero) begin
               state_in = ST_EMIT;
            end else if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_emit = 1'b1;
               if (sts.cnt_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `PARS_ASSERT(a_no_overwrite, clock, reset, cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready), "response word overwritten")
   `PARS_ASSERT(a_busy_after_accept, clock, reset, accept |=> (state_ff != ST_IDLE), "request accepted without work")
   `PARS_ASSERT(a_rsp_hold, clock, reset, (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff, "response word dropped")

endmodule

@@ rtl/core/pinned_address_range_set_unit.sv @@
// ----------------------------------------------------------------------------
// Pinned address range set unit
// Up to CAPACITY unique nonzero addresses with insert, clear, membership
// and sorted-offset range queries.
// ----------------------------------------------------------------------------
// Takes one request word at a time. Insert, a membership query and an offsets
// query that finds nothing scan the address RAM one entry per cycle, then let
// the last read pass compare and sort before the single response word. An
// offsets query with hits emits one word per cycle while the receiver is ready,
// up to 16 words in ascending offset order with last set on the final one.
// Clear skips the scan. A full table drops an insert and flags status. The
// response register decouples the channels, so a new request is taken while
// the final response word is still waiting.
module pinned_address_range_set_unit (
   input  logic       clock,
   input  logic       reset,
   pars_req_if.sink   req_bus,
   pars_rsp_if.source rsp_bus
);

   pars_pkg::pars_cmd_type cmd;
   pars_pkg::pars_sts_type sts;

   pars_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_operation (req_bus.operation),
      .req_ready     (req_bus.ready),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .cmd           (cmd),
      .sts           (sts)
   );

   pars_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_operation   (req_bus.operation),
      .req_address     (req_bus.address),
      .req_object_size (req_bus.object_size),
      .rsp_found       (rsp_bus.found),
      .rsp_offset      (rsp_bus.offset),
      .rsp_last        (rsp_bus.last),
      .rsp_status      (rsp_bus.status)
   );

endmodule

@@ tb/pars_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pinned address range set checker
// Watches the request and response channels. Keeps its own copy of the
// pinned address table, predicts the response words of each accepted
// request and compares every accepted response word field by field.
// ----------------------------------------------------------------------------
module pars_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [1:0]                  req_operation,
   input  logic [pars_pkg::ADDR_W-1:0] req_address,
   input  logic [pars_pkg::SIZE_W-1:0] req_object_size,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic                        rsp_found,
   input  logic [pars_pkg::SIZE_W-1:0] rsp_offset,
   input  logic                        rsp_last,
   input  logic                        rsp_status,
   output int                          failures,
   output int                          pending
);

   typedef struct packed {
      logic                        found;
      logic [pars_pkg::SIZE_W-1:0] offset;
      logic                        last;
      logic                        status;
   } rsp_word_type;

   rsp_word_type                expected_words [$];
   logic [pars_pkg::ADDR_W-1:0] pinned_addr [pars_pkg::CAPACITY];
   logic                        pinned_valid [pars_pkg::CAPACITY];

   function automatic void push_word(logic found, logic [pars_pkg::SIZE_W-1:0] offset,
                                     logic last, logic status);
      rsp_word_type w;
      w.found  = found;
      w.offset = offset;
      w.last   = last;
      w.status = status;
      expected_words.push_back(w);
   endfunction

   // Update the table copy and queue the words this request must produce.
   function automatic void predict_request(pars_pkg::pars_op_type op,
                                           logic [pars_pkg::ADDR_W-1:0] addr,
                                           logic [pars_pkg::SIZE_W-1:0] size);
      int                          free_slot;
      logic                        ignored;
      logic [pars_pkg::ADDR_W:0]   span_end;
      logic [pars_pkg::SIZE_W-1:0] offs [pars_pkg::CAPACITY];
      logic [pars_pkg::SIZE_W-1:0] v;
      int                          n;
      int                          j;
      int                          emit_n;
      free_slot = -1;
      n         = 0;
      case (op)
         pars_pkg::OP_INSERT: begin
            ignored = (addr == '0);
            for (int i = 0; i < pars_pkg::CAPACITY; i++) begin
               if (pinned_valid[i]) begin
                  if (pinned_addr[i] == addr) ignored = 1'b1;
               end else if (free_slot < 0) begin
                  free_slot = i;
               end
            end
            if (ignored) begin
               push_word(1'b0, '0, 1'b1, 1'b0);
            end else if (free_slot < 0) begin
               push_word(1'b0, '0, 1'b1, 1'b1);
            end else begin
               pinned_addr[free_slot]  = addr;
               pinned_valid[free_slot] = 1'b1;
               push_word(1'b0, '0, 1'b1, 1'b0);
            end
         end
         pars_pkg::OP_CLEAR: begin
            for (int i = 0; i < pars_pkg::CAPACITY; i++) pinned_valid[i] = 1'b0;
            push_word(1'b0, '0, 1'b1, 1'b0);
         end
         default: begin
            // range end is one bit wider than an address, so it never wraps
            span_end = {1'b0, addr} +
                       {{(pars_pkg::ADDR_W + 1 - pars_pkg::SIZE_W){1'b0}}, size};
            if (addr != '0) begin
               for (int i = 0; i < pars_pkg::CAPACITY; i++) begin
                  if (pinned_valid[i] && pinned_addr[i] >= addr &&
                      {1'b0, pinned_addr[i]} < span_end) begin
                     v = pars_pkg::SIZE_W'(pinned_addr[i] - addr);
                     j = n;
                     while (j > 0 && offs[j - 1] > v) begin
                        offs[j] = offs[j - 1];
                        j--;
                     end
                     offs[j] = v;
                     n++;
                  end
               end
            end
            if (op == pars_pkg::OP_MEMBER) begin
               push_word(n > 0, '0, 1'b1, 1'b0);
            end else if (n == 0) begin
               push_word(1'b0, '0, 1'b1, 1'b0);
            end else begin
               emit_n = (n > pars_pkg::MAX_RESULTS) ? pars_pkg::MAX_RESULTS : n;
               for (int k = 0; k < emit_n; k++)
                  push_word(1'b1, offs[k], k == emit_n - 1, 1'b0);
            end
         end
      endcase
   endfunction

   function automatic void check_field(string field, logic [pars_pkg::SIZE_W-1:0] want,
                                       logic [pars_pkg::SIZE_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         for (int i = 0; i < pars_pkg::CAPACITY; i++) pinned_valid[i] = 1'b0;
         expected_words.delete();
         failures = 0;
      end else begin
         // compare before predicting: a word leaving now belongs to an older request
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected response word, expected none, actual %0b/%0h/%0b/%0b",
                        $time, rsp_found, rsp_offset, rsp_last, rsp_status);
               failures++;
            end else begin
               want = expected_words.pop_front();
               check_field("found", want.found, rsp_found);
               check_field("offset", want.offset, rsp_offset);
               check_field("last", want.last, rsp_last);
               check_field("status", want.status, rsp_status);
            end
         end
         if (req_valid && req_ready)
            predict_request(pars_pkg::pars_op_type'(req_operation), req_address,
                            req_object_size);
      end
      pending = expected_words.size();
   end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pinned address range set unit testbench
// Directed corner requests, then random insert/query/clear traffic clustered
// around moving address regions, with random idling on both channels and one
// long response hold-off. The checker module judges every response word.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int RANDOM_WORDS    = 350;
   localparam int CALM_TAIL       = 60;
   localparam int HOLD_OFF_AT     = 100;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 3 * (pars_pkg::CAPACITY + 4);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic idling_on;
   logic hold_off_req;
   int   cycle_count = 0;
   int   failures;
   int   pending;

   logic [pars_pkg::ADDR_W-1:0] region_base;
   logic [pars_pkg::SIZE_W-1:0] region_spread;
   logic [pars_pkg::ADDR_W-1:0] recent_addrs [$];

   pars_req_if req_bus ();
   pars_rsp_if rsp_bus ();

   pinned_address_range_set_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   pars_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_bus.valid),
      .req_ready       (req_bus.ready),
      .req_operation   (req_bus.operation),
      .req_address     (req_bus.address),
      .req_object_size (req_bus.object_size),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_found       (rsp_bus.found),
      .rsp_offset      (rsp_bus.offset),
      .rsp_last        (rsp_bus.last),
      .rsp_status      (rsp_bus.status),
      .failures        (failures),
      .pending         (pending)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Response side: random stalls, plus one long hold-off on request.
   initial begin : rsp_side
      int   gap;
      logic held_off;
      held_off      = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !held_off) begin
            held_off = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            rsp_bus.ready <= 1'b1;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_word(pars_pkg::pars_op_type op, logic [pars_pkg::ADDR_W-1:0] addr,
                            logic [pars_pkg::SIZE_W-1:0] size);
      int gap;
      @(negedge clock);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.operation   <= op;
      req_bus.address     <= addr;
      req_bus.object_size <= size;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic pick_region();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0:       region_base = {pars_pkg::ADDR_W{1'b1}} -
                                pars_pkg::ADDR_W'($urandom_range(0, 8191));
         default: region_base = r[pars_pkg::ADDR_W-1:0];
      endcase
      case ($urandom_range(0, 2))
         0:       region_spread = 63;
         1:       region_spread = 4095;
         default: region_spread = $urandom;
      endcase
   endtask

   // Mostly inserts and queries aimed at the current region, so tables fill
   // up and queries hit; the rest is zero, wild or duplicate traffic.
   task automatic random_word();
      logic [63:0]                 r;
      logic [pars_pkg::ADDR_W-1:0] addr;
      logic [pars_pkg::SIZE_W-1:0] size;
      int                          pick;
      int                          sub;
      pick = $urandom_range(0, 99);
      sub  = $urandom_range(0, 9);
      r    = {$urandom, $urandom};
      if (pick < 2) begin
         if ($urandom_range(0, 1) == 0) pick_region();
         send_word(pars_pkg::OP_CLEAR, r[pars_pkg::ADDR_W-1:0], $urandom);
      end else if (pick < 50) begin
         if (sub == 0)
            addr = '0;
         else if (sub < 3 && recent_addrs.size() > 0)
            addr = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
         else if (sub == 3)
            addr = r[pars_pkg::ADDR_W-1:0];
         else
            addr = region_base + pars_pkg::ADDR_W'($urandom_range(0, region_spread));
         recent_addrs.push_back(addr);
         if (recent_addrs.size() > 32) void'(recent_addrs.pop_front());
         send_word(pars_pkg::OP_INSERT, addr, $urandom);
      end else begin
         if (sub == 0)
            addr = '0;
         else if (sub == 1)
            addr = r[pars_pkg::ADDR_W-1:0];
         else if (sub == 2 && recent_addrs.size() > 0)
            addr = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
         else
            addr = region_base + pars_pkg::ADDR_W'($urandom_range(0, region_spread / 4));
         case ($urandom_range(0, 7))
            0:       size = '0;
            1:       size = $urandom;
            2:       size = {pars_pkg::SIZE_W{1'b1}};
            default: size = $urandom_range(1, region_spread);
         endcase
         send_word((pick < 72) ? pars_pkg::OP_MEMBER : pars_pkg::OP_OFFSETS, addr, size);
      end
   endtask

   initial begin
      req_bus.valid       = 1'b0;
      req_bus.operation   = pars_pkg::OP_INSERT;
      req_bus.address     = '0;
      req_bus.object_size = '0;
      idling_on           = 1'b1;
      hold_off_req        = 1'b0;
      pick_region();
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // empty table, zero insert, extreme addresses, duplicate
      send_word(pars_pkg::OP_MEMBER, 48'h1, {pars_pkg::SIZE_W{1'b1}});
      send_word(pars_pkg::OP_OFFSETS, 48'h1, {pars_pkg::SIZE_W{1'b1}});
      send_word(pars_pkg::OP_INSERT, '0, '0);
      send_word(pars_pkg::OP_INSERT, {pars_pkg::ADDR_W{1'b1}}, '0);
      send_word(pars_pkg::OP_INSERT, 48'h1, {pars_pkg::SIZE_W{1'b1}});
      send_word(pars_pkg::OP_INSERT, 48'h1, '0);
      // zero base, zero size, single hit
      send_word(pars_pkg::OP_MEMBER, '0, {pars_pkg::SIZE_W{1'b1}});
      send_word(pars_pkg::OP_MEMBER, 48'h1, '0);
      send_word(pars_pkg::OP_MEMBER, 48'h1, 32'h1);
      // fill the table, then overflow it
      for (int k = 0; k < pars_pkg::CAPACITY - 2; k++)
         send_word(pars_pkg::OP_INSERT, pars_pkg::ADDR_W'(48'h10 + 3 * k), '0);
      send_word(pars_pkg::OP_INSERT, 48'h8000_0000, '0);
      // many hits in order, then a range running past the top of the space
      send_word(pars_pkg::OP_OFFSETS, 48'h1, 32'h100);
      send_word(pars_pkg::OP_OFFSETS, 48'hFFFF_FFFF_0000, {pars_pkg::SIZE_W{1'b1}});
      send_word(pars_pkg::OP_CLEAR, '0, '0);
      send_word(pars_pkg::OP_MEMBER, 48'h1, {pars_pkg::SIZE_W{1'b1}});

      for (int k = 0; k < RANDOM_WORDS; k++) begin
         if (k == HOLD_OFF_AT) hold_off_req = 1'b1;
         if (k == RANDOM_WORDS - CALM_TAIL) idling_on = 1'b0;
         random_word();
      end
      @(negedge clock);
      req_bus.valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
